>>> rtl/u8dw_pkg.sv
// u8dw_pkg: shared types, constants and the column width table of the
// utf8 display width block; no dependencies
package u8dw_pkg;

    localparam int SUM_BITS = 16;
    localparam int CP_BITS  = 21;
    localparam int COL_BITS = 2;
    localparam int CNT_BITS = 3;

    localparam logic [CP_BITS-1:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [COL_BITS-1:0] REPL_COLS = 2'd1;

    localparam int NZERO = 6;
    localparam int NWIDE = 10;

    localparam logic [CP_BITS-1:0] ZERO_LO [NZERO] = '{
        21'h0300, 21'h1AB0, 21'h200B, 21'h20D0, 21'hFE00, 21'hFE20
    };
    localparam logic [CP_BITS-1:0] ZERO_HI [NZERO] = '{
        21'h036F, 21'h1AFF, 21'h200D, 21'h20FF, 21'hFE0F, 21'hFE2F
    };
    localparam logic [CP_BITS-1:0] WIDE_LO [NWIDE] = '{
        21'h1100, 21'h2E80, 21'hAC00, 21'hF900, 21'hFE30,
        21'hFF00, 21'hFFE0, 21'h1F300, 21'h1F900, 21'h20000
    };
    localparam logic [CP_BITS-1:0] WIDE_HI [NWIDE] = '{
        21'h115F, 21'hA4CF, 21'hD7A3, 21'hFAFF, 21'hFE6F,
        21'hFF60, 21'hFFE6, 21'h1F64F, 21'h1F9FF, 21'h3FFFD
    };

    // one decoded byte worth of results: count-1 replacement characters
    // followed by the final code point
    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic [CP_BITS-1:0]  last_cp;
        logic [COL_BITS-1:0] last_cols;
        logic                last_text;
    } job_t;

    function automatic logic [COL_BITS-1:0] column_count(input logic [CP_BITS-1:0] cp);
        logic zero;
        logic wide;
        zero = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0);
        wide = 1'b0;
        for (int k = 0; k < NZERO; k++) begin
            if (cp >= ZERO_LO[k] && cp <= ZERO_HI[k]) begin
                zero = 1'b1;
            end
        end
        for (int k = 0; k < NWIDE; k++) begin
            if (cp >= WIDE_LO[k] && cp <= WIDE_HI[k]) begin
                wide = 1'b1;
            end
        end
        if (zero) begin
            return 2'd0;
        end else if (wide) begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

endpackage

>>> rtl/u8dw_decode.sv
// u8dw_decode: utf8 sequence decoder with the pending job register
// depends on u8dw_pkg
module u8dw_decode
    import u8dw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       job_valid,
    output job_t       job,
    input  logic       job_take
);

    logic [CP_BITS-1:0]  pp_reg, pp_next;
    logic [1:0]          need_reg, need_next;
    logic [1:0]          taken_reg, taken_next;
    logic                job_valid_reg, job_valid_next;
    job_t                job_reg, job_next;

    logic                accept;
    logic                pending;
    logic                is_cont;
    logic [CNT_BITS-1:0] flush_cnt;
    logic [CNT_BITS-1:0] cnt;
    logic [CP_BITS-1:0]  tail_cp;
    logic [CP_BITS-1:0]  cont_pp;
    logic [7:0]          b;

    assign b        = s_tdata;
    assign s_tready = !job_valid_reg || job_take;
    assign accept   = s_tvalid && s_tready;
    assign pending  = (need_reg != 2'd0);
    assign is_cont  = (b[7:6] == 2'b10);
    assign cont_pp  = {pp_reg[CP_BITS-7:0], b[5:0]};
    assign flush_cnt = (pending && !is_cont) ? ({1'b0, taken_reg} + 3'd1) : 3'd0;

    always_comb begin
        cnt        = 3'd0;
        tail_cp    = REPLACEMENT;
        pp_next    = pp_reg;
        need_next  = need_reg;
        taken_next = taken_reg;
        if (pending && is_cont) begin
            pp_next    = cont_pp;
            need_next  = need_reg - 2'd1;
            taken_next = taken_reg + 2'd1;
            if (need_reg == 2'd1) begin
                cnt        = 3'd1;
                tail_cp    = cont_pp;
                pp_next    = '0;
                taken_next = 2'd0;
            end else if (s_tlast) begin
                // lead plus every continuation taken so far
                cnt = {1'b0, taken_reg} + 3'd2;
            end
        end else begin
            pp_next    = '0;
            need_next  = 2'd0;
            taken_next = 2'd0;
            priority if (b[7] == 1'b0) begin
                cnt     = flush_cnt + 3'd1;
                tail_cp = {13'd0, b};
            end else if (b[7:5] == 3'b110) begin
                pp_next   = {16'd0, b[4:0]};
                need_next = 2'd1;
                cnt       = s_tlast ? flush_cnt + 3'd1 : flush_cnt;
            end else if (b[7:4] == 4'b1110) begin
                pp_next   = {17'd0, b[3:0]};
                need_next = 2'd2;
                cnt       = s_tlast ? flush_cnt + 3'd1 : flush_cnt;
            end else if (b[7:3] == 5'b11110) begin
                pp_next   = {18'd0, b[2:0]};
                need_next = 2'd3;
                cnt       = s_tlast ? flush_cnt + 3'd1 : flush_cnt;
            end else begin
                cnt = flush_cnt + 3'd1;
            end
        end
        if (s_tlast) begin
            pp_next    = '0;
            need_next  = 2'd0;
            taken_next = 2'd0;
        end
    end

    always_comb begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        if (job_take) begin
            job_valid_next = 1'b0;
        end
        if (accept && cnt != 3'd0) begin
            job_valid_next    = 1'b1;
            job_next.count     = cnt;
            job_next.last_cp   = tail_cp;
            job_next.last_cols = column_count(tail_cp);
            job_next.last_text = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_reg        <= '0;
            need_reg      <= 2'd0;
            taken_reg     <= 2'd0;
            job_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pp_reg    <= pp_next;
                need_reg  <= need_next;
                taken_reg <= taken_next;
            end
            job_valid_reg <= job_valid_next;
        end
        job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (job_reg.count != 3'd0 && job_reg.count <= 3'd4))
        else $error("queued job with bad result count");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (need_reg == 2'd0 && taken_reg == 2'd0))
        else $error("decoder state left pending after final byte");

    a_last_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (job_valid_reg && job_reg.last_text))
        else $error("final byte produced no results");

endmodule

>>> rtl/u8dw_emit.sv
// u8dw_emit: steps through the results of one job, keeps the running
// column total and holds the result register; depends on u8dw_pkg
module u8dw_emit
    import u8dw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  job_t                job,
    output logic                job_take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CP_BITS-1:0]  out_cp,
    output logic [COL_BITS-1:0] out_cols,
    output logic [SUM_BITS-1:0] out_total,
    output logic                out_run_end,
    output logic                out_text_done
);

    localparam logic [SUM_BITS:0] SUM_CAP = {1'b0, {SUM_BITS{1'b1}}};

    logic [1:0]          idx_reg, idx_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CP_BITS-1:0]  cp_reg;
    logic [COL_BITS-1:0] cols_reg;
    logic [SUM_BITS-1:0] total_reg;
    logic                run_end_reg;
    logic                text_done_reg;

    logic                out_free;
    logic                emit_fire;
    logic                is_final;
    logic [CP_BITS-1:0]  cur_cp;
    logic [COL_BITS-1:0] cur_cols;
    logic [SUM_BITS:0]   sum_wide;
    logic [SUM_BITS-1:0] sum_sat;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = job_valid && out_free;
    assign is_final  = ({1'b0, idx_reg} == job.count - 3'd1);
    assign cur_cp    = is_final ? job.last_cp : REPLACEMENT;
    assign cur_cols  = is_final ? job.last_cols : REPL_COLS;
    assign sum_wide  = {1'b0, sum_reg} + {{(SUM_BITS-1){1'b0}}, cur_cols};
    assign sum_sat   = (sum_wide > SUM_CAP) ? SUM_CAP[SUM_BITS-1:0]
                                            : sum_wide[SUM_BITS-1:0];
    assign job_take  = emit_fire && is_final;

    always_comb begin
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit_fire) begin
            m_tvalid_next = 1'b1;
            idx_next      = is_final ? 2'd0 : idx_reg + 2'd1;
            sum_next      = (is_final && job.last_text) ? '0 : sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (emit_fire) begin
            cp_reg        <= cur_cp;
            cols_reg      <= cur_cols;
            total_reg     <= sum_sat;
            run_end_reg   <= is_final;
            text_done_reg <= is_final && job.last_text;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign out_cp        = cp_reg;
    assign out_cols      = cols_reg;
    assign out_total     = total_reg;
    assign out_run_end   = run_end_reg;
    assign out_text_done = text_done_reg;

    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> ({1'b0, idx_reg} < job.count))
        else $error("result index beyond job count");

    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && is_final && job.last_text) |=> (sum_reg == '0))
        else $error("running total not cleared after string end");

    a_done_implies_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && text_done_reg) |-> run_end_reg)
        else $error("string end flagged on a result that is not a byte's last");

endmodule

>>> rtl/utf8_display_width_top.sv
// utf8_display_width_top: top level of the utf8 display width block
// depends on u8dw_pkg, u8dw_decode and u8dw_emit
//
// Takes a string one byte per request (s_tlast on the final byte) and gives
// one result request per decoded code point: the code point (U+FFFD for
// malformed input), its terminal column count and the saturating running
// width of the string. A byte is taken every cycle while each byte causes at
// most one result and the receiver keeps up; a byte that causes more (up to
// four, on broken sequences) holds the result side, since the emitter puts
// out one result per cycle while the receiver is ready, and the input stalls
// while that job drains. Lead and mid-sequence bytes cause no result unless
// they break a sequence or end the string, and wait on a draining job.
// Results go via the job and result registers. The running total
// returns to zero after the last result of a string, which carries m_tlast.
module utf8_display_width_top
    import u8dw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [20:0] code_point, [22:21] columns,
                                   // [38:23] total_columns, [39] zero
    output logic        m_tuser,   // run_end
    output logic        m_tlast    // text_done
);

    localparam int FIELD_BITS = CP_BITS + COL_BITS + SUM_BITS;
    localparam int PAD_BITS   = 40 - FIELD_BITS;

    // job handed from the decoder to the emitter
    logic                job_valid;
    job_t                job;
    logic                job_take;

    logic [CP_BITS-1:0]  out_cp;
    logic [COL_BITS-1:0] out_cols;
    logic [SUM_BITS-1:0] out_total;

    // byte decoding; next byte is taken as the emitter finishes this job
    u8dw_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    // one result per cycle while the receiver is ready, into the result register; running total here
    u8dw_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (job_valid),
        .job           (job),
        .job_take      (job_take),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_cp        (out_cp),
        .out_cols      (out_cols),
        .out_total     (out_total),
        .out_run_end   (m_tuser),
        .out_text_done (m_tlast)
    );

    // pack fields from the lowest bit up, zero fill to whole bytes
    assign m_tdata = {{PAD_BITS{1'b0}}, out_total, out_cols, out_cp};

endmodule

>>> test/utf8_display_width_top_tb.sv
// utf8_display_width_top_tb: self-checking bench for the utf8 display width block,
// driving byte strings with random gaps and checking every decoded code point
// depends on u8dw_pkg (REPLACEMENT) and rtl/utf8_display_width_top.sv
module utf8_display_width_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import u8dw_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_OFF    = 150;

    // zero-width and double-width code point spans
    localparam logic [20:0] NOWIDTH_LO [6] = '{
        21'h0300, 21'h1AB0, 21'h200B, 21'h20D0, 21'hFE00, 21'hFE20
    };
    localparam logic [20:0] NOWIDTH_HI [6] = '{
        21'h036F, 21'h1AFF, 21'h200D, 21'h20FF, 21'hFE0F, 21'hFE2F
    };
    localparam logic [20:0] DOUBLE_LO [10] = '{
        21'h1100, 21'h2E80, 21'hAC00, 21'hF900, 21'hFE30,
        21'hFF00, 21'hFFE0, 21'h1F300, 21'h1F900, 21'h20000
    };
    localparam logic [20:0] DOUBLE_HI [10] = '{
        21'h115F, 21'hA4CF, 21'hD7A3, 21'hFAFF, 21'hFE6F,
        21'hFF60, 21'hFFE6, 21'h1F64F, 21'h1F9FF, 21'h3FFFD
    };

    // first code point past each width change; random points land one below,
    // on, or one above these
    localparam int SPAN_EDGES [36] = '{
        'h20, 'h7F, 'hA0, 'h300, 'h370, 'h1100, 'h1160, 'h1AB0, 'h1B00,
        'h200B, 'h200E, 'h20D0, 'h2100, 'h2E80, 'hA4D0, 'hAC00, 'hD7A4,
        'hF900, 'hFB00, 'hFE00, 'hFE10, 'hFE20, 'hFE30, 'hFE70, 'hFF00,
        'hFF61, 'hFFE0, 'hFFE7, 'hFFFD, 'h1F300, 'h1F650, 'h1F900,
        'h1FA00, 'h20000, 'h3FFFE, 'h1FFFFF
    };

    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  columns;
        logic [15:0] total;
        logic        run_end;
        logic        text_done;
    } glyph_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // decoded glyphs still owed by the block, oldest first
    glyph_t      pending_glyphs[$];
    // bytes of the string being assembled for sending
    logic [7:0]  text_q[$];

    // shadow decoder state
    logic [20:0] seq_partial;
    logic [1:0]  seq_needed;
    logic [1:0]  seq_taken;
    logic [15:0] width_sum;
    int          byte_results;

    int          fault_count  = 0;
    int          cycle_count  = 0;
    int          items_sent   = 0;
    int          stall_left   = 0;
    bit          sender_calm  = 1'b0;
    bit          receiver_calm = 1'b0;
    bit          hold_request = 1'b0;
    logic        hold_off     = 1'b0;

    utf8_display_width_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // shadow decoder: same column tables and sequence rules as the block
    // ------------------------------------------------------------------

    function automatic logic [1:0] glyph_columns(input logic [20:0] cp);
        if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
            return 2'd0;
        end
        for (int k = 0; k < 6; k++) begin
            if (cp >= NOWIDTH_LO[k] && cp <= NOWIDTH_HI[k]) begin
                return 2'd0;
            end
        end
        for (int k = 0; k < 10; k++) begin
            if (cp >= DOUBLE_LO[k] && cp <= DOUBLE_HI[k]) begin
                return 2'd2;
            end
        end
        return 2'd1;
    endfunction

    // append one glyph; the running width sticks at all ones
    task automatic emit_glyph(input logic [20:0] cp);
        glyph_t      g;
        logic [16:0] grown;
        g.code_point = cp;
        g.columns    = glyph_columns(cp);
        grown        = {1'b0, width_sum} + {15'd0, g.columns};
        width_sum    = grown[16] ? 16'hFFFF : grown[15:0];
        g.total      = width_sum;
        g.run_end    = 1'b0;
        g.text_done  = 1'b0;
        pending_glyphs.insert(pending_glyphs.size(), g);
        byte_results++;
    endtask

    // abandoned sequence: one replacement for the lead and for each
    // continuation already taken
    task automatic flush_sequence();
        for (int k = 0; k <= seq_taken && byte_results < 4; k++) begin
            emit_glyph(REPLACEMENT);
        end
        seq_partial = '0;
        seq_needed  = '0;
        seq_taken   = '0;
    endtask

    task automatic start_sequence(input logic [7:0] b);
        if (b < 8'h80) begin
            emit_glyph({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
            seq_partial = {16'd0, b[4:0]};
            seq_needed  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            seq_partial = {17'd0, b[3:0]};
            seq_needed  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            seq_partial = {18'd0, b[2:0]};
            seq_needed  = 2'd3;
        end else begin
            // lone continuation or a lead that no sequence starts with
            emit_glyph(REPLACEMENT);
        end
        seq_taken = '0;
    endtask

    task automatic decode_text_byte(input logic [7:0] b, input logic final_byte);
        glyph_t g;
        byte_results = 0;
        if (seq_needed != 0) begin
            if (b[7:6] == 2'b10) begin
                seq_partial = {seq_partial[14:0], b[5:0]};
                seq_needed  = seq_needed - 2'd1;
                seq_taken   = seq_taken + 2'd1;
                if (seq_needed == 0) begin
                    emit_glyph(seq_partial);
                    seq_partial = '0;
                    seq_taken   = '0;
                end
            end else begin
                // broken sequence: flush it, then decode this byte afresh
                flush_sequence();
                start_sequence(b);
            end
        end else begin
            start_sequence(b);
        end
        // string ends inside a sequence
        if (final_byte && seq_needed != 0) begin
            flush_sequence();
        end
        if (byte_results > 0) begin
            g           = pending_glyphs[pending_glyphs.size() - 1];
            g.run_end   = 1'b1;
            g.text_done = final_byte;
            pending_glyphs[pending_glyphs.size() - 1] = g;
        end
        if (final_byte) begin
            seq_partial = '0;
            seq_needed  = '0;
            seq_taken   = '0;
            width_sum   = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // request traffic
    // ------------------------------------------------------------------

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    // offer one byte and hold it until the block takes it; the shadow
    // decoder runs at the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic final_byte);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= final_byte;
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
        decode_text_byte(b, final_byte);
    endtask

    // send the assembled string, tlast on its final byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    function automatic int bytes_for(input logic [20:0] cp);
        if (cp < 21'h80) begin
            return 1;
        end else if (cp < 21'h800) begin
            return 2;
        end else if (cp < 21'h10000) begin
            return 3;
        end
        return 4;
    endfunction

    // encode cp in nb bytes (possibly overlong) and keep only the first few
    task automatic push_point(input logic [20:0] cp, input int nb, input int keep);
        logic [7:0] enc[4];
        case (nb)
            1: begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) begin
            text_q.insert(text_q.size(), enc[i]);
        end
    endtask

    function automatic logic [20:0] random_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 21'($urandom_range(0, 'h7F));
        end else if (r < 30) begin
            return 21'($urandom_range('h20, 'h7E));
        end else if (r < 55) begin
            return 21'(SPAN_EDGES[$urandom_range(0, $size(SPAN_EDGES) - 1)]
                       + $urandom_range(0, 2) - 1);
        end else if (r < 70) begin
            return 21'($urandom_range('h80, 'h7FF));
        end else if (r < 90) begin
            return 21'($urandom_range('h800, 'hFFFF));
        end
        return 21'($urandom_range('h10000, 'h1FFFFF));
    endfunction

    // mostly well-formed characters, some noise and cut-off sequences
    task automatic add_random_piece();
        int          pick;
        int          nb;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        cp   = random_point();
        nb   = bytes_for(cp);
        if (nb < 4 && $urandom_range(0, 9) == 0) begin
            nb++;
        end
        if (pick < 80) begin
            push_point(cp, nb, nb);
        end else if (pick < 86) begin
            text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
        end else if (pick < 91) begin
            text_q.insert(text_q.size(), 8'($urandom_range('h80, 'hBF)));
        end else if (pick < 95) begin
            text_q.insert(text_q.size(), 8'($urandom_range('hF8, 'hFF)));
        end else begin
            if (nb == 1) begin
                nb = 2;
            end
            push_point(cp, nb, $urandom_range(1, nb - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    task automatic check_glyph();
        glyph_t want;
        glyph_t got;
        got.code_point = m_tdata[20:0];
        got.columns    = m_tdata[22:21];
        got.total      = m_tdata[38:23];
        got.run_end    = m_tuser;
        got.text_done  = m_tlast;
        if (pending_glyphs.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
                $display("unexpected result: cp=%h cols=%0d total=%0d run_end=%b done=%b",
                         got.code_point, got.columns, got.total, got.run_end,
                         got.text_done);
            end
        end else begin
            want = pending_glyphs.pop_front();
            if (got !== want || m_tdata[39] !== 1'b0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("mismatch: want cp=%h cols=%0d total=%0d run_end=%b done=%b",
                             want.code_point, want.columns, want.total, want.run_end,
                             want.text_done);
                    $display("          got  cp=%h cols=%0d total=%0d run_end=%b done=%b pad=%b",
                             got.code_point, got.columns, got.total, got.run_end,
                             got.text_done, m_tdata[39]);
                end
            end
        end
    endtask

    // long receiver hold-off, timed here so the ready logic only sees a flag
    initial begin
        forever begin
            wait (hold_request);
            hold_off <= 1'b1;
            repeat (HOLD_OFF) @(posedge aclk);
            hold_off <= 1'b0;
            hold_request = 1'b0;
        end
    end

    // take results at each edge, then pick the next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            check_glyph();
        end
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = receiver_calm ? 0 : pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // control, ascii, delete, lone continuation and an invalid lead
    task automatic test_plain_and_bad_bytes();
        text_q = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hFF};
        send_text();
    endtask

    // two, three and four byte points, the highest one last
    task automatic test_multibyte_points();
        text_q = '{8'hC2, 8'hA9, 8'hE4, 8'hB8, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text();
    endtask

    // sequence broken by ascii, broken by a new lead that the string end
    // cuts off (four results from one byte), and a lone lead at string end
    task automatic test_broken_sequences();
        text_q = '{8'hE2, 8'h82, 8'h41, 8'hF0, 8'h90, 8'h80, 8'hF0};
        send_text();
        text_q = '{8'hC3};
        send_text();
    endtask

    // receiver stops for a long stretch while bytes keep coming
    task automatic test_output_backpressure();
        sender_calm  = 1'b1;
        hold_request = 1'b1;
        repeat (5) begin
            text_q.insert(text_q.size(), 8'hF0);
            text_q.insert(text_q.size(), 8'h90);
            text_q.insert(text_q.size(), 8'h80);
            text_q.insert(text_q.size(), 8'h41);
            text_q.insert(text_q.size(), 8'h48);
            text_q.insert(text_q.size(), 8'h49);
        end
        send_text();
        sender_calm = 1'b0;
    endtask

    task automatic test_random_strings();
        int stop_at;
        int pieces;
        stop_at = items_sent + 400;
        while (items_sent < stop_at) begin
            // some strings run with no idling on one or both sides
            sender_calm   = ($urandom_range(0, 4) == 0);
            receiver_calm = ($urandom_range(0, 4) == 0);
            pieces = $urandom_range(1, 12);
            repeat (pieces) add_random_piece();
            send_text();
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
    endtask

    initial begin
        seq_partial = '0;
        seq_needed  = '0;
        seq_taken   = '0;
        width_sum   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_and_bad_bytes();
        test_multibyte_points();
        test_broken_sequences();
        test_output_backpressure();
        test_random_strings();
        s_tvalid <= 1'b0;

        // drain, then keep watching so the pipeline can show any extras
        while (pending_glyphs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fault_count == 0 && pending_glyphs.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
